FILE: design/timed_motor_command_sequencer_core_assert.svh
// assertion macros shared by the checker of the motor command sequencer
// expects i_clk and i_rst_n in the scope of use
`ifndef TIMED_MOTOR_COMMAND_SEQUENCER_CORE_ASSERT_SVH
`define TIMED_MOTOR_COMMAND_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication
`define TMCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TMCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/tmcs_pkg.sv
// types and fixed codes of the timed motor command sequencer
// no dependencies
`default_nettype none

package tmcs_pkg;

    localparam logic [2:0] FN_LOAD  = 3'd0;
    localparam logic [2:0] FN_START = 3'd1;
    localparam logic [2:0] FN_STOP  = 3'd2;
    localparam logic [2:0] FN_TICK  = 3'd3;
    localparam logic [2:0] FN_QUERY = 3'd4;

    localparam logic [1:0] EV_QSTART = 2'd0;
    localparam logic [1:0] EV_CMD    = 2'd1;
    localparam logic [1:0] EV_FINISH = 2'd2;
    localparam logic [1:0] EV_QUERY  = 2'd3;

    // direction and speed bits of both motors in a store entry
    localparam int DRIVE_W = 18;
    // width used to compare indexes against the store depth
    localparam int ADDR_EXT_W = 9;
    // width used to resize durations
    localparam int DUR_EXT_W = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_QSTART,
        S_CMD,
        S_TICK,
        S_ADV,
        S_FIN,
        S_QRY
    } t_state;

    typedef struct packed {
        logic [1:0]  ev;
        logic [15:0] qid;
        logic [3:0]  step;
        logic [4:0]  len;
        logic [15:0] dur;
        logic        ldir;
        logic [7:0]  lspd;
        logic        rdir;
        logic [7:0]  rspd;
        logic        running;
        logic        id_running;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

FILE: design/tmcs_cmd_store.sv
// command store: one write port, one registered read port
// no dependencies
`default_nettype none

module tmcs_cmd_store #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 34
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: design/timed_motor_command_sequencer_core.sv
// Timed motor command sequencer. Load requests write one entry of the command store,
// and stop requests and ticks while no run is in progress are taken, each in one cycle.
// A start request passes through S_QSTART (queue start result) and S_CMD (the first command
// once its entry has been read), a query through S_QRY, and a tick through S_TICK; it ends
// there when the command keeps running, goes on to S_FIN when the queue finishes and through
// S_ADV to S_CMD when the next command is issued. S_ADV waits for the registered read of the
// single command store read port, and each result state waits while i_out_stall holds a
// result. A new request is taken while the previous result still waits.
// Depends on tmcs_pkg and tmcs_cmd_store.
`default_nettype none

module timed_motor_command_sequencer_core import tmcs_pkg::*; #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int DURATION_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_func,
    input  wire logic [3:0]  i_entry_index,
    input  wire logic        i_left_dir,
    input  wire logic [7:0]  i_left_speed,
    input  wire logic        i_right_dir,
    input  wire logic [7:0]  i_right_speed,
    input  wire logic [15:0] i_step_duration,
    input  wire logic [4:0]  i_queue_size,
    input  wire logic [15:0] i_query_id,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_event_res,
    output logic [15:0]      o_queue_id,
    output logic [3:0]       o_step_index,
    output logic [4:0]       o_queue_length,
    output logic [15:0]      o_cmd_duration,
    output logic             o_drive_left_dir,
    output logic [7:0]       o_drive_left_speed,
    output logic             o_drive_right_dir,
    output logic [7:0]       o_drive_right_speed,
    output logic             o_running,
    output logic             o_id_running,
    output logic             o_last
);

    localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int ENTRY_W = DRIVE_W + DURATION_BITS;
    localparam int TICK_W  = DURATION_BITS + 1;

    t_state                r_state, n_state;
    logic [4:0]            r_index, n_index;
    logic [4:0]            r_size, n_size;
    logic [15:0]           r_qid, n_qid;
    logic                  r_busy, n_busy;
    logic [TICK_W-1:0]     r_elapsed, n_elapsed;
    logic [15:0]           r_query_id, n_query_id;
    logic                  r_out_valid, n_out_valid;
    t_result               r_res, n_res;

    logic                  accept_in;
    logic                  out_free;
    logic [ADDR_EXT_W-1:0] load_ext;
    logic                  load_ok;
    logic                  wr_en;
    logic [DUR_EXT_W-1:0]  in_dur_ext;
    logic [ENTRY_W-1:0]    wr_data;
    logic [ADDR_EXT_W-1:0] index_ext;
    logic [ENTRY_W-1:0]    rd_data;
    logic [DURATION_BITS-1:0] cmd_dur;
    logic [DUR_EXT_W-1:0]  cmd_dur_ext;
    logic [TICK_W-1:0]     tick_inc;
    logic                  tick_done;
    logic                  is_final;
    logic [4:0]            size_nz;
    logic [4:0]            size_sat;
    t_result               res_base;

    assign accept_in = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    assign load_ext   = ADDR_EXT_W'(i_entry_index);
    assign load_ok    = load_ext < ADDR_EXT_W'(QUEUE_DEPTH);
    assign wr_en      = accept_in && (i_func == FN_LOAD) && load_ok;
    assign in_dur_ext = DUR_EXT_W'(i_step_duration);
    assign wr_data    = {i_left_dir, i_left_speed, i_right_dir, i_right_speed,
                         in_dur_ext[DURATION_BITS-1:0]};
    assign index_ext  = ADDR_EXT_W'(r_index);

    tmcs_cmd_store #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (IDX_W),
        .DATA_W (ENTRY_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (load_ext[IDX_W-1:0]),
        .i_wr_data (wr_data),
        .i_rd_addr (index_ext[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign cmd_dur     = rd_data[DURATION_BITS-1:0];
    assign cmd_dur_ext = DUR_EXT_W'(cmd_dur);
    assign tick_inc    = (r_elapsed == '1) ? r_elapsed : r_elapsed + TICK_W'(1);
    assign tick_done   = tick_inc > {1'b0, cmd_dur};
    assign is_final    = ({1'b0, r_index} + 6'd1) >= {1'b0, r_size};

    assign size_nz  = (i_queue_size == 5'd0) ? 5'd1 : i_queue_size;
    assign size_sat = (ADDR_EXT_W'(size_nz) > ADDR_EXT_W'(QUEUE_DEPTH)) ?
                      5'(QUEUE_DEPTH) : size_nz;

    always_comb begin
        res_base            = '0;
        res_base.qid        = r_qid;
        res_base.step       = r_index[3:0];
        res_base.len        = r_size;
        res_base.running    = r_busy;
    end

    always_comb begin
        n_state     = r_state;
        n_index     = r_index;
        n_size      = r_size;
        n_qid       = r_qid;
        n_busy      = r_busy;
        n_elapsed   = r_elapsed;
        n_query_id  = r_query_id;
        n_out_valid = r_out_valid && i_out_stall;
        n_res       = r_res;
        case (r_state)
            S_IDLE: begin
                if (accept_in) begin
                    case (i_func)
                        FN_START: begin
                            n_qid     = r_qid + 16'd1;
                            n_size    = size_sat;
                            n_index   = '0;
                            n_busy    = 1'b1;
                            n_elapsed = '0;
                            n_state   = S_QSTART;
                        end
                        FN_STOP: begin
                            n_busy = 1'b0;
                        end
                        FN_TICK: begin
                            if (r_busy) begin
                                n_state = S_TICK;
                            end
                        end
                        FN_QUERY: begin
                            n_query_id = i_query_id;
                            n_state    = S_QRY;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_QSTART: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_res       = res_base;
                    n_res.ev    = EV_QSTART;
                    n_state     = S_CMD;
                end
            end
            S_CMD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_res       = res_base;
                    n_res.ev    = EV_CMD;
                    n_res.dur   = cmd_dur_ext[15:0];
                    n_res.ldir  = rd_data[ENTRY_W-1];
                    n_res.lspd  = rd_data[ENTRY_W-2 -: 8];
                    n_res.rdir  = rd_data[ENTRY_W-10];
                    n_res.rspd  = rd_data[ENTRY_W-11 -: 8];
                    n_res.last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_TICK: begin
                if (!tick_done) begin
                    n_elapsed = tick_inc;
                    n_state   = S_IDLE;
                end else if (is_final) begin
                    n_elapsed = tick_inc;
                    n_busy    = 1'b0;
                    n_state   = S_FIN;
                end else begin
                    n_index   = r_index + 5'd1;
                    n_elapsed = '0;
                    n_state   = S_ADV;
                end
            end
            S_ADV: begin
                // wait for the new entry to come out of the store
                n_state = S_CMD;
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_res       = res_base;
                    n_res.ev    = EV_FINISH;
                    n_res.last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_QRY: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_res            = res_base;
                    n_res.ev         = EV_QUERY;
                    n_res.id_running = r_busy && (r_query_id == r_qid);
                    n_res.last       = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_index     <= '0;
            r_size      <= 5'd1;
            r_qid       <= '0;
            r_busy      <= 1'b0;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_index     <= n_index;
            r_size      <= n_size;
            r_qid       <= n_qid;
            r_busy      <= n_busy;
            r_elapsed   <= n_elapsed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_query_id <= n_query_id;
        r_res      <= n_res;
    end

    assign o_out_valid         = r_out_valid;
    assign o_event_res         = r_res.ev;
    assign o_queue_id          = r_res.qid;
    assign o_step_index        = r_res.step;
    assign o_queue_length      = r_res.len;
    assign o_cmd_duration      = r_res.dur;
    assign o_drive_left_dir    = r_res.ldir;
    assign o_drive_left_speed  = r_res.lspd;
    assign o_drive_right_dir   = r_res.rdir;
    assign o_drive_right_speed = r_res.rspd;
    assign o_running           = r_res.running;
    assign o_id_running        = r_res.id_running;
    assign o_last              = r_res.last;

endmodule

`default_nettype wire

FILE: design/tmcs_checker.sv
// port-level checks of the motor command sequencer, bound to its top level
// depends on tmcs_pkg and timed_motor_command_sequencer_core_assert.svh
`default_nettype none

`include "timed_motor_command_sequencer_core_assert.svh"

module tmcs_checker import tmcs_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic [2:0]  i_func,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [1:0]  o_event_res,
    input wire logic [7:0]  o_drive_left_speed,
    input wire logic [7:0]  o_drive_right_speed,
    input wire logic        o_running,
    input wire logic        o_last
);

    // a waiting result is not dropped
    `TMCS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")

    // a start request always keeps the block busy for its results
    `TMCS_ASSERT_NEXT(a_start_busy, i_in_valid && !o_in_stall && (i_func == FN_START), o_in_stall, "start request not held")

    // queue start is never the last result and always shows a run
    `TMCS_ASSERT_NOW(a_qstart, o_out_valid && (o_event_res == EV_QSTART), !o_last && o_running, "bad queue start result")

    // finish drives both speeds to zero and ends the run
    `TMCS_ASSERT_NOW(a_finish, o_out_valid && (o_event_res == EV_FINISH), (o_drive_left_speed == 8'd0) && (o_drive_right_speed == 8'd0) && !o_running && o_last, "bad finish result")

endmodule

bind timed_motor_command_sequencer_core tmcs_checker u_tmcs_checker (.*);

`default_nettype wire
